### design/hash_set_chained_buckets_defines.svh
// Assertion macros for the hash set block.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef HASH_SET_CHAINED_BUCKETS_DEFINES_SVH
`define HASH_SET_CHAINED_BUCKETS_DEFINES_SVH

// same-cycle implication
`define HSCB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSCB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hscb_pkg.sv
// Shared types and constants of the hash set block.
// No dependencies.
package hscb_pkg;

	localparam int CFG_W    = 5;   // bucket_count register width
	localparam int KEY_IN_W = 32;  // key field width on the stream
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	// register word index (paddr[2])
	localparam logic REG_BUCKET_COUNT = 1'b0;
	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(16);

	typedef enum logic [1:0] {
		REQ_ADD      = 2'd0,
		REQ_REMOVE   = 2'd1,
		REQ_CONTAINS = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_ABSENT = 2'd1,
		STAT_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_MOD,
		FSM_BASE,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_DONE
	} fsm_t;

endpackage

### design/hscb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hscb_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 128
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/hscb_mod.sv
// Bit-serial remainder unit: key modulo a small divisor, one key bit a cycle.
// Depends on hscb_pkg.
module hscb_mod #(
	parameter int KW = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [KW-1:0]             key,
	input  logic [hscb_pkg::CFG_W-1:0] divisor,
	output logic                      done,
	output logic [hscb_pkg::CFG_W-1:0] rem
);

	localparam int CNT_W = $clog2(KW + 1);
	localparam int RW    = hscb_pkg::CFG_W;

	logic [KW-1:0]    sh_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [RW:0]      trial;
	logic [RW:0]      diff;

	assign trial = {rem_q, sh_q[KW-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// one-cycle pulse after the last key bit
			done_q <= !start && run_q && (cnt_q == CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(KW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= key;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			sh_q <= sh_q << 1;
			// remainder stays below the divisor, so one subtract suffices
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[RW-1:0];
			end else begin
				rem_q <= trial[RW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### design/hash_set_chained_buckets.sv
// Top level of the hash set with bounded chained buckets.
// Depends on hscb_pkg, hscb_mod, hscb_ram and hash_set_chained_buckets_defines.svh.
//
// Usage notes
//  - Requests come in on the s_ stream: s_tuser carries the operation (add, remove,
//    contains), s_tdata the key. One result per request leaves on the m_ stream:
//    m_tdata bit 0 is found (key present before the request), bits 2:1 the status
//    (ok, remove of an absent key, bucket full on add).
//  - bucket_count sits on the APB port at word 0; write it only while idle.
//  - After reset a clearing pass walks all NUM_BUCKETS*CHAIN_DEPTH slots (128 by
//    default), one per cycle, with s_tready low. APB stays usable throughout.
//  - One request at a time: the bucket index comes from a bit-serial remainder unit
//    (one key bit a cycle), then the bucket's slots are read from the slot RAM one
//    per cycle. The next request is taken in the cycle after the result is loaded
//    into the output register.
//  - The result sits in an output register; while the receiver stalls the block still
//    takes and works the next request, and only holds it at the end until the
//    output register frees.
module hash_set_chained_buckets #(
	parameter int NUM_BUCKETS = 16,
	parameter int CHAIN_DEPTH = 8,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // [31:0] key
	input  logic [1:0]                    s_tuser,   // [1:0] req_type
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [0] found, [2:1] status, rest zero
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hscb_pkg::APB_AW-1:0]   paddr,
	input  logic [hscb_pkg::APB_DW-1:0]   pwdata,
	output logic [hscb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	`include "hash_set_chained_buckets_defines.svh"

	localparam int SKW   = (KEY_WIDTH < hscb_pkg::KEY_IN_W) ? KEY_WIDTH : hscb_pkg::KEY_IN_W;
	localparam int SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DW    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int CW    = $clog2(CHAIN_DEPTH + 1);
	localparam int RW    = hscb_pkg::CFG_W;
	localparam int EW    = ($clog2(NUM_BUCKETS + 1) > RW) ? $clog2(NUM_BUCKETS + 1) : RW;
	localparam int PW    = AW + RW;
	localparam int MW    = SKW + 1;   // RAM word: {valid, key}

	// ---------------------------------------------------------------- config
	logic [RW-1:0] bucket_count_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == hscb_pkg::REG_BUCKET_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= hscb_pkg::BUCKET_COUNT_RST;
		end else if (cfg_wr) begin
			bucket_count_q <= pwdata[RW-1:0];
		end
	end

	assign prdata = (paddr[2] == hscb_pkg::REG_BUCKET_COUNT)
		? hscb_pkg::APB_DW'(bucket_count_q) : '0;

	// effective divisor: zero acts as one, saturate at NUM_BUCKETS
	logic [RW-1:0] eff_div;
	always_comb begin
		if (bucket_count_q == '0) begin
			eff_div = RW'(1);
		end else if (EW'(bucket_count_q) > EW'(NUM_BUCKETS)) begin
			eff_div = RW'(NUM_BUCKETS);
		end else begin
			eff_div = bucket_count_q;
		end
	end

	// ---------------------------------------------------------------- state
	hscb_pkg::fsm_t state_q, state_d;

	logic               in_acc;
	logic [SKW-1:0]     key_q;
	hscb_pkg::req_t     req_q;
	logic [AW-1:0]      base_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [CW-1:0]      sc_cnt_q;
	logic               chk_v_q;
	logic [DW-1:0]      chk_idx_q;
	logic               hit_q;
	logic [DW-1:0]      hit_idx_q;
	logic               free_q;
	logic [DW-1:0]      free_idx_q;
	logic               res_found_q;
	hscb_pkg::status_t  res_status_q;
	logic               out_v_q;
	logic               found_o_q;
	hscb_pkg::status_t  status_o_q;

	logic               mod_done;
	logic [RW-1:0]      mod_rem;
	logic [PW-1:0]      base_prod;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [MW-1:0]      ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [MW-1:0]      ram_rdata;

	logic               slot_match;
	logic               slot_free;
	logic               scan_last;
	logic               out_load;

	assign in_acc    = s_tvalid && s_tready;
	assign base_prod = PW'(mod_rem) * PW'(CHAIN_DEPTH);
	assign scan_last = (sc_cnt_q == CW'(CHAIN_DEPTH));
	assign out_load  = (state_q == hscb_pkg::FSM_DONE) && (!out_v_q || m_tready);

	assign slot_match = ram_rdata[SKW] && (ram_rdata[SKW-1:0] == key_q);
	assign slot_free  = !ram_rdata[SKW];

	hscb_mod #(
		.KW(SKW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc),
		.key     (s_tdata[SKW-1:0]),
		.divisor (eff_div),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	hscb_ram #(
		.WIDTH(MW),
		.DEPTH(SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hscb_pkg::FSM_CLEAR: begin
				if (clr_cnt_q == AW'(SLOTS - 1)) state_d = hscb_pkg::FSM_IDLE;
			end
			hscb_pkg::FSM_IDLE: begin
				if (s_tvalid) state_d = hscb_pkg::FSM_MOD;
			end
			hscb_pkg::FSM_MOD: begin
				if (mod_done) state_d = hscb_pkg::FSM_BASE;
			end
			hscb_pkg::FSM_BASE:   state_d = hscb_pkg::FSM_SCAN;
			hscb_pkg::FSM_SCAN: begin
				if (scan_last) state_d = hscb_pkg::FSM_DECIDE;
			end
			hscb_pkg::FSM_DECIDE: state_d = hscb_pkg::FSM_DONE;
			hscb_pkg::FSM_DONE: begin
				if (out_load) state_d = hscb_pkg::FSM_IDLE;
			end
			default:              state_d = hscb_pkg::FSM_CLEAR;
		endcase
	end

	// outputs of the sequencer: handshake and RAM ports
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = base_q;
		ram_wdata = {1'b0, key_q};
		ram_re    = 1'b0;
		ram_raddr = base_q + AW'(sc_cnt_q);
		case (state_q)
			hscb_pkg::FSM_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
			end
			hscb_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
			end
			hscb_pkg::FSM_SCAN: begin
				ram_re = !scan_last;
			end
			hscb_pkg::FSM_DECIDE: begin
				case (req_q)
					hscb_pkg::REQ_ADD: begin
						if (!hit_q && free_q) begin
							ram_we    = 1'b1;
							ram_waddr = base_q + AW'(free_idx_q);
							ram_wdata = {1'b1, key_q};
						end
					end
					hscb_pkg::REQ_REMOVE: begin
						if (hit_q) begin
							ram_we    = 1'b1;
							ram_waddr = base_q + AW'(hit_idx_q);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hscb_pkg::FSM_CLEAR;
			clr_cnt_q <= '0;
			sc_cnt_q  <= '0;
			chk_v_q   <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hscb_pkg::FSM_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == hscb_pkg::FSM_BASE) begin
				sc_cnt_q <= '0;
				chk_v_q  <= 1'b0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end
			if (state_q == hscb_pkg::FSM_SCAN) begin
				if (!scan_last) sc_cnt_q <= sc_cnt_q + 1'b1;
				chk_v_q <= !scan_last;
				// keep the first hit and the first empty slot
				if (chk_v_q && slot_match && !hit_q) hit_q <= 1'b1;
				if (chk_v_q && slot_free && !free_q) free_q <= 1'b1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= s_tdata[SKW-1:0];
			req_q <= hscb_pkg::req_t'(s_tuser);
		end
		if (state_q == hscb_pkg::FSM_BASE) base_q <= base_prod[AW-1:0];
		if (state_q == hscb_pkg::FSM_SCAN) begin
			chk_idx_q <= DW'(sc_cnt_q);
			if (chk_v_q && slot_match && !hit_q) hit_idx_q <= chk_idx_q;
			if (chk_v_q && slot_free && !free_q) free_idx_q <= chk_idx_q;
		end
		if (state_q == hscb_pkg::FSM_DECIDE) begin
			res_found_q <= hit_q;
			case (req_q)
				hscb_pkg::REQ_ADD: begin
					if (!hit_q && !free_q) begin
						res_status_q <= hscb_pkg::STAT_FULL;
					end else begin
						res_status_q <= hscb_pkg::STAT_OK;
					end
				end
				hscb_pkg::REQ_REMOVE: begin
					if (!hit_q) begin
						res_status_q <= hscb_pkg::STAT_ABSENT;
					end else begin
						res_status_q <= hscb_pkg::STAT_OK;
					end
				end
				default: res_status_q <= hscb_pkg::STAT_OK;
			endcase
		end
		if (out_load) begin
			found_o_q  <= res_found_q;
			status_o_q <= res_status_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'b0, status_o_q, found_o_q};

	// ---------------------------------------------------------------- checks
	`HSCB_ASSERT_IMP(a_no_write_in_scan, state_q == hscb_pkg::FSM_SCAN, !ram_we,
		"slot RAM written during bucket scan")
	`HSCB_ASSERT_NXT(a_accept_starts_mod, in_acc, state_q == hscb_pkg::FSM_MOD && !mod_done,
		"accepted request did not start the remainder unit")
	`HSCB_ASSERT_IMP(a_full_not_found,
		m_tvalid && m_tdata[2:1] == hscb_pkg::STAT_FULL, !m_tdata[0],
		"bucket-full status reported with found set")

endmodule
